[rtl/x2r_pkg.sv]
// ----------------------------------------------------------------------------
// x2r_pkg
// Shared constants and types for the XYZ to RGB max-normalised converter.
// ----------------------------------------------------------------------------
package x2r_pkg;

  localparam int unsigned SampleWidthDef = 16;
  localparam int unsigned CoeffW         = 16;
  localparam int unsigned RowW           = 3 * CoeffW;
  localparam int unsigned LevelW         = 8;
  localparam int unsigned NumRows        = 3;
  localparam int unsigned RegIdxW        = 2;
  localparam int unsigned FifoDepthDef   = 4;

  // configuration register indexes
  typedef enum logic [RegIdxW-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_NONE  = 2'd3
  } x2r_reg_e;

  // queue status as seen by its neighbours
  typedef struct packed {
    logic full;
    logic valid;
  } x2r_qstat_t;

endpackage

[rtl/x2r_front.sv]
// ----------------------------------------------------------------------------
// x2r_front
// Takes XYZ words, raises zero Y to one LSB and forms the squared Y term.
// ----------------------------------------------------------------------------
module x2r_front import x2r_pkg::*; #(
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [SampleWidth-1:0]   x_i,
  input  logic [SampleWidth-1:0]   y_i,
  input  logic [SampleWidth-1:0]   z_i,
  input  x2r_qstat_t               qstat_i,
  output logic                     push_o,
  output logic [3*SampleWidth+1:0] push_data_o
);

  localparam int unsigned F  = SampleWidth - 2;
  localparam int unsigned VW = SampleWidth + 2;

  logic                   valid_q;
  logic [SampleWidth-1:0] x_q, z_q;
  logic [VW-1:0]          vy_q;
  logic [SampleWidth-1:0] t;
  logic [2*SampleWidth-1:0] sq;
  logic                   adv;

  always_comb begin
    t   = (y_i == '0) ? SampleWidth'(1) : y_i;
    sq  = t * t;
    adv = !valid_q || !qstat_i.full;
  end

  assign in_stall_o  = !adv;
  assign push_o      = valid_q && !qstat_i.full;
  assign push_data_o = {x_q, vy_q, z_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && in_valid_i) begin
      x_q  <= x_i;
      z_q  <= z_i;
      vy_q <= sq[2*SampleWidth-1:F];  // truncated square, F fraction bits
    end
  end

endmodule

[rtl/x2r_fifo.sv]
// ----------------------------------------------------------------------------
// x2r_fifo
// Short queue between the front and back ends.
// ----------------------------------------------------------------------------
module x2r_fifo import x2r_pkg::*; #(
  parameter int unsigned DataW = 50,
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [DataW-1:0] push_data_i,
  input  logic             pop_i,
  output logic [DataW-1:0] pop_data_o,
  output x2r_qstat_t       qstat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [DataW-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;

  assign qstat_o.full  = (cnt_q == CntW'(Depth));
  assign qstat_o.valid = (cnt_q != '0);
  assign pop_data_o    = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

[rtl/x2r_back.sv]
// ----------------------------------------------------------------------------
// x2r_back
// Matrix product, clamp, largest search and pipelined 8-bit scaling divide.
// ----------------------------------------------------------------------------
module x2r_back import x2r_pkg::*; #(
  parameter int unsigned SampleWidth = SampleWidthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  x2r_qstat_t               qstat_i,
  output logic                     pop_o,
  input  logic [3*SampleWidth+1:0] pop_data_i,
  input  logic [RowW-1:0]          row_i [NumRows],
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [LevelW-1:0]        red_o,
  output logic [LevelW-1:0]        green_o,
  output logic [LevelW-1:0]        blue_o,
  output logic                     all_clamped_o
);

  localparam int unsigned VW   = SampleWidth + 2;
  localparam int unsigned PW   = CoeffW + VW + 1;
  localparam int unsigned SW   = PW + 2;
  localparam int unsigned CW   = SW - 1;
  localparam int unsigned NW   = CW + LevelW;
  localparam int unsigned NDiv = LevelW;
  localparam int unsigned NV   = 3 + NDiv;

  logic adv;
  logic [NV-1:0] v_q;

  // operands
  logic [SampleWidth-1:0] in_x, in_z;
  logic [VW-1:0]          in_vy;
  logic signed [PW-1:0]   op [3];
  logic signed [PW-1:0]   prod [NumRows][3];
  logic signed [PW-1:0]   prod_q [NumRows][3];
  logic signed [SW-1:0]   sum [NumRows];
  logic [CW-1:0]          comp_q [NumRows];
  logic [CW-1:0]          big;

  // divider stages: index 0 is the initial load
  logic [NW-1:0]     rem_q [NDiv+1][NumRows];
  logic [LevelW-1:0] quo_q [NDiv+1][NumRows];
  logic [CW-1:0]     den_q [NDiv+1];
  logic              zero_q [NDiv+1];
  logic [NW-1:0]     rem_n [NDiv][NumRows];
  logic              bit_n [NDiv][NumRows];

  logic              out_valid_q;
  logic [LevelW-1:0] lvl_q [NumRows];
  logic              clamp_q;

  assign adv   = !out_valid_q || !out_stall_i;
  assign pop_o = qstat_i.valid && adv;
  assign {in_x, in_vy, in_z} = pop_data_i;

  always_comb begin
    op[0] = PW'($signed({1'b0, in_x}));
    op[1] = PW'($signed({1'b0, in_vy}));
    op[2] = PW'($signed({1'b0, in_z}));
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod[r][c] = PW'($signed(row_i[r][CoeffW*c +: CoeffW])) * op[c];
      end
      sum[r] = SW'(prod_q[r][0]) + SW'(prod_q[r][1]) + SW'(prod_q[r][2]);
    end
    big = (comp_q[0] > comp_q[1]) ? comp_q[0] : comp_q[1];
    if (comp_q[2] > big) begin
      big = comp_q[2];
    end
    // one quotient bit a stage, most significant first
    for (int k = 0; k < NDiv; k++) begin
      for (int r = 0; r < NumRows; r++) begin
        bit_n[k][r] = rem_q[k][r] >= (NW'(den_q[k]) << (NDiv - 1 - k));
        rem_n[k][r] = bit_n[k][r] ? rem_q[k][r] - (NW'(den_q[k]) << (NDiv - 1 - k))
                                  : rem_q[k][r];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q         <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v_q         <= {v_q[NV-2:0], pop_o};
      out_valid_q <= v_q[NV-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int r = 0; r < NumRows; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_q[r][c] <= prod[r][c];
        end
        comp_q[r] <= sum[r][SW-1] ? '0 : sum[r][CW-1:0];
        // comp * 255
        rem_q[0][r] <= (NW'(comp_q[r]) << LevelW) - NW'(comp_q[r]);
        quo_q[0][r] <= '0;
        for (int k = 0; k < NDiv; k++) begin
          rem_q[k+1][r] <= rem_n[k][r];
          quo_q[k+1][r] <= {quo_q[k][r][LevelW-2:0], bit_n[k][r]};
        end
        lvl_q[r] <= zero_q[NDiv] ? '0 : quo_q[NDiv][r];
      end
      den_q[0]  <= big;
      zero_q[0] <= (big == '0);
      for (int k = 0; k < NDiv; k++) begin
        den_q[k+1]  <= den_q[k];
        zero_q[k+1] <= zero_q[k];
      end
      clamp_q <= zero_q[NDiv];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign red_o         = lvl_q[0];
  assign green_o       = lvl_q[1];
  assign blue_o        = lvl_q[2];
  assign all_clamped_o = clamp_q;

`ifndef NO_ASSERTIONS
  // flagged words carry zero levels
  a_clamp_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && clamp_q |-> lvl_q[0] == '0 && lvl_q[1] == '0 && lvl_q[2] == '0)
    else $error("clamped word with non-zero level");

  // otherwise the largest component lands on full scale
  a_full_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !clamp_q |->
      lvl_q[0] == '1 || lvl_q[1] == '1 || lvl_q[2] == '1)
    else $error("no component at full scale");

  // a stalled output freezes the whole back end
  a_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(v_q) && !$past(pop_o))
    else $error("back end moved while output stalled");
`endif

endmodule

[rtl/xyz_to_rgb_max_normalized_unit.sv]
// ----------------------------------------------------------------------------
// xyz_to_rgb_max_normalized_unit
// CIE XYZ to RGB levels, scaled so the largest component reads 255.
// ----------------------------------------------------------------------------
// Takes one XYZ word a cycle while in_stall_o is low (unsigned, SampleWidth-2
// fraction bits) and returns one RGB word for each, in order. Y is raised to
// one LSB if zero and the vector (X, Y*Y, Z) goes through the loaded signed
// Q3.12 matrix; each component is clamped at zero, then scaled as
// comp*255/largest, truncated. If all three clamp to zero the levels are 0 and
// all_clamped is set. Throughput is one word per cycle while out_stall_i
// is low. A word accepted at an edge goes in turn through the front register
// (square), the queue write, the matrix multiply, the sum and clamp, the
// largest search, eight restoring divide stages (one quotient bit each) and
// the output register. A FifoDepth-entry queue (4 by default) lets the front
// keep taking words while the back end is held by out_stall_i. The user must
// write rows through cfg_* only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module xyz_to_rgb_max_normalized_unit import x2r_pkg::*; #(
  parameter int unsigned SampleWidth = SampleWidthDef,
  parameter int unsigned FifoDepth   = FifoDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration
  input  logic                   cfg_we_i,
  input  logic [RegIdxW-1:0]     cfg_idx_i,
  input  logic [RowW-1:0]        cfg_data_i,
  // input words
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SampleWidth-1:0] x_value_i,
  input  logic [SampleWidth-1:0] y_value_i,
  input  logic [SampleWidth-1:0] z_value_i,
  // output words
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [LevelW-1:0]      red_level_o,
  output logic [LevelW-1:0]      green_level_o,
  output logic [LevelW-1:0]      blue_level_o,
  output logic                   all_clamped_o
);

  localparam int unsigned QW = 3 * SampleWidth + 2;

  logic [RowW-1:0] row_q [NumRows];
  x2r_qstat_t      qstat;
  logic            push, pop;
  logic [QW-1:0]   push_data, pop_data;

  // matrix rows; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRows; r++) begin
        row_q[r] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (x2r_reg_e'(cfg_idx_i))
        REG_RED:   row_q[0] <= cfg_data_i;
        REG_GREEN: row_q[1] <= cfg_data_i;
        REG_BLUE:  row_q[2] <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  x2r_front #(.SampleWidth(SampleWidth)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .x_i         (x_value_i),
    .y_i         (y_value_i),
    .z_i         (z_value_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  x2r_fifo #(.DataW(QW), .Depth(FifoDepth)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .qstat_o     (qstat)
  );

  x2r_back #(.SampleWidth(SampleWidth)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .qstat_i       (qstat),
    .pop_o         (pop),
    .pop_data_i    (pop_data),
    .row_i         (row_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .red_o         (red_level_o),
    .green_o       (green_level_o),
    .blue_o        (blue_level_o),
    .all_clamped_o (all_clamped_o)
  );

endmodule

[test/x2r_checker.sv]
// ----------------------------------------------------------------------------
// x2r_checker
// Watches both channels, predicts each RGB word and compares it on arrival.
// ----------------------------------------------------------------------------
module x2r_checker import x2r_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [RegIdxW-1:0]      cfg_idx_i,
  input  logic [RowW-1:0]         cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic [SampleWidthDef-1:0] x_value_i,
  input  logic [SampleWidthDef-1:0] y_value_i,
  input  logic [SampleWidthDef-1:0] z_value_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic [LevelW-1:0]       red_level_i,
  input  logic [LevelW-1:0]       green_level_i,
  input  logic [LevelW-1:0]       blue_level_i,
  input  logic                    all_clamped_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      seen_o,
  output int                      clamped_seen_o
);

  localparam int FracB = SampleWidthDef - 2;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
  } rgb_word_t;

  logic [RowW-1:0] rows [NumRows];
  rgb_word_t rgb_due [$];

  function automatic longint row_dot(logic [RowW-1:0] row, longint vx, longint vy,
                                     longint vz);
    longint s;
    s = longint'($signed(row[15:0])) * vx + longint'($signed(row[31:16])) * vy
      + longint'($signed(row[47:32])) * vz;
    return (s < 0) ? 0 : s;
  endfunction

  function automatic rgb_word_t convert_xyz(logic [15:0] x, logic [15:0] y,
                                            logic [15:0] z);
    longint t, vy, r, g, b, big;
    rgb_word_t w;
    t  = (y == 0) ? 1 : longint'(y);
    vy = (t * t) >>> FracB;
    r  = row_dot(rows[REG_RED], x, vy, z);
    g  = row_dot(rows[REG_GREEN], x, vy, z);
    b  = row_dot(rows[REG_BLUE], x, vy, z);
    big = (r > g) ? r : g;
    if (b > big) big = b;
    if (big == 0) begin
      w = '{8'd0, 8'd0, 8'd0, 1'b1};
    end else begin
      w.red     = 8'((r * 255) / big);
      w.green   = 8'((g * 255) / big);
      w.blue    = 8'((b * 255) / big);
      w.clamped = 1'b0;
    end
    return w;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t on %s: got %0d, want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    seen_o = 0;
    clamped_seen_o = 0;
  end

  assign pending_o = rgb_due.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_word_t w;
    if (!rst_ni) begin
      foreach (rows[i]) rows[i] <= '0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (rgb_due.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          w = rgb_due.pop_front();
          if (red_level_i !== w.red) report_mismatch("red", red_level_i, w.red);
          if (green_level_i !== w.green) report_mismatch("green", green_level_i, w.green);
          if (blue_level_i !== w.blue) report_mismatch("blue", blue_level_i, w.blue);
          if (all_clamped_i !== w.clamped)
            report_mismatch("all_clamped", all_clamped_i, w.clamped);
          seen_o++;
          if (w.clamped) clamped_seen_o++;
        end
      end
      if (in_valid_i && !in_stall_i) rgb_due.push_back(convert_xyz(x_value_i, y_value_i,
                                                                  z_value_i));
      if (cfg_we_i && cfg_idx_i < NumRows) rows[cfg_idx_i] <= cfg_data_i;
    end
  end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the XYZ to RGB max-normalised converter.
// ----------------------------------------------------------------------------
// Several matrix settings (zero, identity, extremes, sRGB-style, random)
// each get a batch of XYZ words; both sides idle at random with quiet
// stretches. The checker predicts and compares every word.
// ----------------------------------------------------------------------------
module tb;
  import x2r_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [RegIdxW-1:0] cfg_idx_i = REG_RED;
  logic [RowW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] x_value_i = '0, y_value_i = '0, z_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] red_level_o, green_level_o, blue_level_o;
  logic all_clamped_o;
  int errors, pending, seen, clamped_seen;
  bit quiet;  // no idling on either side
  int sent;

  always #2 clk_i = ~clk_i;

  xyz_to_rgb_max_normalized_unit dut (.*);

  x2r_checker chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_i(in_stall_o), .x_value_i, .y_value_i, .z_value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .red_level_i(red_level_o),
    .green_level_i(green_level_o), .blue_level_i(blue_level_o),
    .all_clamped_i(all_clamped_o), .errors_o(errors), .pending_o(pending),
    .seen_o(seen), .clamped_seen_o(clamped_seen)
  );

  // receiver: stalls about 31 percent of the time unless quiet
  always @(negedge clk_i) out_stall_i <= !quiet && ($urandom_range(99) < 31);

  task automatic write_row(x2r_reg_e idx, logic [RowW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // write all three rows once the pipeline has drained
  task automatic load_matrix(logic [RowW-1:0] r, logic [RowW-1:0] g, logic [RowW-1:0] b);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    write_row(REG_RED, r);
    write_row(REG_GREEN, g);
    write_row(REG_BLUE, b);
    write_row(REG_NONE, {RowW{1'b1}});  // out of range, must be ignored
  endtask

  // send one word; valid may stay high across back-to-back words
  task automatic send_xyz(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    x_value_i <= x;
    y_value_i <= y;
    z_value_i <= z;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    sent++;
  endtask

  function automatic logic [RowW-1:0] rand_row();
    return {16'($urandom), 16'($urandom), 16'($urandom)};
  endfunction

  task automatic random_batch(int n);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(3);
      case (k)
        0: send_xyz(16'($urandom_range(3)), 16'($urandom_range(3)), 16'($urandom_range(3)));
        1: send_xyz(16'hFFFF - 16'($urandom_range(3)), 16'($urandom), 16'hFFFF);
        default: send_xyz(16'($urandom), 16'($urandom), 16'($urandom));
      endcase
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    quiet = 1'b0;
    sent = 0;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    // reset matrix is zero: every word clamps
    send_xyz(16'h0000, 16'h0000, 16'h0000);
    send_xyz(16'hFFFF, 16'hFFFF, 16'hFFFF);
    in_valid_i <= 1'b0;
    // identity matrix, 1.0 = 4096
    load_matrix(48'h0000_0000_1000, 48'h0000_1000_0000, 48'h1000_0000_0000);
    send_xyz(16'h0000, 16'h0000, 16'h0000);   // zero Y raised to one LSB
    send_xyz(16'hFFFF, 16'h0000, 16'hFFFF);
    send_xyz(16'h4000, 16'h4000, 16'h4000);   // three-way tie
    send_xyz(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_xyz(16'h0001, 16'h0001, 16'h0000);
    send_xyz(16'h1234, 16'h8000, 16'hABCD);
    in_valid_i <= 1'b0;
    // extremes: most positive and most negative coefficients
    load_matrix(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h7FFF_8000_7FFF);
    send_xyz(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_xyz(16'h0000, 16'hFFFF, 16'h0000);
    send_xyz(16'hFFFF, 16'h0000, 16'h0000);
    send_xyz(16'h0000, 16'h0001, 16'hFFFF);
    in_valid_i <= 1'b0;
    random_batch(150);
    // a typical XYZ to sRGB style matrix
    load_matrix(48'hF80A_E6A0_33D7, 48'h00AA_1E03_F0EB, 48'h4393_F2F9_00E4);
    quiet = 1'b1;
    random_batch(250);
    quiet = 1'b0;
    random_batch(200);
    for (int ph = 0; ph < 5; ph++) begin
      load_matrix(rand_row(), rand_row(), rand_row());
      random_batch(200);
    end
    while (pending != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    $display("%0d words sent, %0d checked, %0d of them fully clamped, over 9 matrices",
             sent, seen, clamped_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("Mismatches found");
    $finish;
  end

endmodule
